// ===== sv/dtp_pkg.sv =====
// Shared types, constants and lookup functions of the date and timestamp text parser.
package dtp_pkg;

	// Default number of fraction digits accepted after the dot.
	localparam int FRACTION_DIGITS_DEF = 6;

	// Character codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Text lengths and positions.
	localparam int POS_W    = 5;
	localparam int DATE_LEN = 10;
	localparam int TIME_LEN = 19;
	localparam int FRAC_POS = 20;

	// Field and datapath widths.
	localparam int ACC_W    = 7;
	localparam int US_W     = 20;
	localparam int DAY_W    = 23;
	localparam int HMS_W    = 17;
	localparam int SEC_W    = 39;
	localparam int SEC_LO_W = 20;
	localparam int VAL_W    = 59;

	// Arithmetic constants.
	localparam int US_DIGITS     = 6;
	localparam int US_PER_SEC    = 1000000;
	localparam int SEC_PER_DAY   = 86400;
	localparam int SEC_PER_HOUR  = 3600;
	localparam int SEC_PER_MIN   = 60;
	localparam int DAYS_PER_CENT = 36524;
	localparam int DAYS_PER_YEAR = 365;
	// Offset of 1970-01-01 in the March-based day count, plus one for the 1-based day.
	localparam int EPOCH_SHIFT   = 719469;
	localparam int MAX_HOUR      = 23;
	localparam int MAX_MIN_SEC   = 59;

	// Accumulators of the value being read. The year is kept as two two-digit halves.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             err;
		logic [ACC_W-1:0] year_hi;
		logic [ACC_W-1:0] year_lo;
		logic [ACC_W-1:0] month;
		logic [ACC_W-1:0] day;
		logic [ACC_W-1:0] hour;
		logic [ACC_W-1:0] minute;
		logic [ACC_W-1:0] second;
		logic [US_W-1:0]  frac;
	} acc_t;

	// Shift one decimal digit into a two-digit accumulator.
	function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
			input logic [3:0] dig);
		return ACC_W'(acc * ACC_W'(10) + ACC_W'(dig));
	endfunction

	// Shift one decimal digit into the fraction accumulator.
	function automatic logic [US_W-1:0] add_frac_digit(input logic [US_W-1:0] acc,
			input logic [3:0] dig);
		return US_W'(acc * US_W'(10) + US_W'(dig));
	endfunction

	// Days in a month, with February set by the leap flag.
	function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		unique case (mon)
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	// First day of a month in a year that starts in March.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] start;
		unique case (mp)
			4'd0:    start = 9'd0;
			4'd1:    start = 9'd31;
			4'd2:    start = 9'd61;
			4'd3:    start = 9'd92;
			4'd4:    start = 9'd122;
			4'd5:    start = 9'd153;
			4'd6:    start = 9'd184;
			4'd7:    start = 9'd214;
			4'd8:    start = 9'd245;
			4'd9:    start = 9'd275;
			4'd10:   start = 9'd306;
			4'd11:   start = 9'd337;
			default: start = 9'd0;
		endcase
		return start;
	endfunction

	// Factor that turns a fraction with the given digit count into microseconds.
	function automatic logic [US_W-1:0] frac_scale(input logic [3:0] cnt);
		logic [US_W-1:0] scale;
		unique case (cnt)
			4'd0:    scale = US_W'(1000000);
			4'd1:    scale = US_W'(100000);
			4'd2:    scale = US_W'(10000);
			4'd3:    scale = US_W'(1000);
			4'd4:    scale = US_W'(100);
			4'd5:    scale = US_W'(10);
			default: scale = US_W'(1);
		endcase
		return scale;
	endfunction

endpackage

// ===== sv/date_timestamp_text_parser_core.sv =====
// Top level of the date and timestamp text parser: character scan and result pipeline.
// Throughput: one character word per cycle unless the output stalls; the scan of each
// character updates small accumulators in the cycle it is accepted.
// The result word passes through five registers after the last character is accepted
// (stages 1 to 5, the day and microsecond arithmetic split over them).
// The whole pipeline stalls only while a result waits on the output with out_ready low.
// Reset clears the scan accumulators and pipeline valid bits and sets parse_mode to 1.
module date_timestamp_text_parser_core #(
	parameter int FRACTION_DIGITS = dtp_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic                     cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               char_code,
	input  logic                     last_char,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     status,
	output logic signed [dtp_pkg::VAL_W-1:0] epoch_value
);
	import dtp_pkg::*;

	localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);
	localparam int MAX_LEN = FRAC_POS + FRACTION_DIGITS;
	localparam int PHI_W = VAL_W - SEC_LO_W;
	localparam int PLO_W = SEC_LO_W + US_W;

	logic             mode_q;
	acc_t             acc_q, acc_d;
	logic [CNT_W-1:0] fcnt_q, fcnt_d;
	logic             en;
	logic             in_fire;
	logic             is_dig;
	logic [3:0]       dig;
	logic [7:0]       dig_raw;

	// Stage 1: accumulators of a finished value.
	logic             v_s1, mode_s1;
	acc_t             acc_s1;
	logic [CNT_W-1:0] fcnt_s1;

	// Stage 2: checks, day count, time of day, scaled fraction.
	logic                    v_s2, mode_s2, bad_s2;
	logic signed [DAY_W-1:0] days_s2;
	logic [HMS_W-1:0]        hms_s2;
	logic [US_W-1:0]         frac_s2;

	// Stage 3: total seconds.
	logic                    v_s3, mode_s3, bad_s3;
	logic signed [DAY_W-1:0] days_s3;
	logic [SEC_W-1:0]        secs_s3;
	logic [US_W-1:0]         frac_s3;

	// Stage 4: partial products of the microsecond value.
	logic                    v_s4, mode_s4, bad_s4;
	logic signed [DAY_W-1:0] days_s4;
	logic [PHI_W-1:0]        phi_s4;
	logic [PLO_W-1:0]        plo_s4;
	logic [US_W-1:0]         frac_s4;

	// Stage 5: output register.
	logic                    v_s5, bad_s5;
	logic [VAL_W-1:0]        val_s5;

	// Pipeline advances unless a result is held on the output.
	assign en       = !v_s5 || out_ready;
	assign in_ready = en;
	assign in_fire  = in_valid && en;

	// Character classification.
	assign dig_raw = char_code - CH_ZERO;
	assign dig     = dig_raw[3:0];
	assign is_dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

	// Scan of one character at the current position.
	always_comb begin
		acc_d  = acc_q;
		fcnt_d = fcnt_q;
		priority if (acc_q.pos <= POS_W'(3)) begin
			if (!is_dig) acc_d.err = 1'b1;
			else if (!acc_q.pos[1]) acc_d.year_hi = add_digit(acc_q.year_hi, dig);
			else acc_d.year_lo = add_digit(acc_q.year_lo, dig);
		end else if (acc_q.pos == POS_W'(4) || acc_q.pos == POS_W'(7)) begin
			if (char_code != CH_DASH) acc_d.err = 1'b1;
		end else if (acc_q.pos == POS_W'(5) || acc_q.pos == POS_W'(6)) begin
			if (is_dig) acc_d.month = add_digit(acc_q.month, dig);
			else acc_d.err = 1'b1;
		end else if (acc_q.pos == POS_W'(8) || acc_q.pos == POS_W'(9)) begin
			if (is_dig) acc_d.day = add_digit(acc_q.day, dig);
			else acc_d.err = 1'b1;
		end else if (acc_q.pos == POS_W'(10)) begin
			if (char_code != CH_SPACE && char_code != CH_T) acc_d.err = 1'b1;
		end else if (acc_q.pos == POS_W'(11) || acc_q.pos == POS_W'(12)) begin
			if (is_dig) acc_d.hour = add_digit(acc_q.hour, dig);
			else acc_d.err = 1'b1;
		end else if (acc_q.pos == POS_W'(13) || acc_q.pos == POS_W'(16)) begin
			if (char_code != CH_COLON) acc_d.err = 1'b1;
		end else if (acc_q.pos == POS_W'(14) || acc_q.pos == POS_W'(15)) begin
			if (is_dig) acc_d.minute = add_digit(acc_q.minute, dig);
			else acc_d.err = 1'b1;
		end else if (acc_q.pos == POS_W'(17) || acc_q.pos == POS_W'(18)) begin
			if (is_dig) acc_d.second = add_digit(acc_q.second, dig);
			else acc_d.err = 1'b1;
		end else if (acc_q.pos == POS_W'(19)) begin
			if (char_code != CH_DOT) acc_d.err = 1'b1;
		end else if (int'(acc_q.pos) < MAX_LEN) begin
			if (!is_dig) begin
				acc_d.err = 1'b1;
			end else begin
				// Digits past the sixth are checked and dropped.
				if (int'(fcnt_q) < US_DIGITS) acc_d.frac = add_frac_digit(acc_q.frac, dig);
				fcnt_d = fcnt_q + CNT_W'(1);
			end
		end else begin
			acc_d.err = 1'b1;
		end
		// Position saturates at its largest value.
		if (acc_q.pos != '1) acc_d.pos = acc_q.pos + POS_W'(1);
	end

	// Mode register and accumulators; a last character starts a new value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			acc_q  <= '0;
			fcnt_q <= '0;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			if (in_fire) begin
				if (last_char) begin
					acc_q  <= '0;
					fcnt_q <= '0;
				end else begin
					acc_q  <= acc_d;
					fcnt_q <= fcnt_d;
				end
			end
		end
	end

	// Stage 2 logic: field checks and day count from March-based years.
	logic                    leap_c, bad_c, borrow_c;
	logic [4:0]              dim_c;
	logic signed [7:0]       cent_c;
	logic [ACC_W-1:0]        ylo_c;
	logic [3:0]              mp_c;
	logic signed [DAY_W-1:0] days_c;
	logic [HMS_W-1:0]        hms_c;
	logic [2*US_W-1:0]       frac_prod_c;

	always_comb begin
		leap_c = (acc_s1.year_lo != '0) ? (acc_s1.year_lo[1:0] == 2'b00)
			: (acc_s1.year_hi[1:0] == 2'b00);
		dim_c  = month_days(acc_s1.month[3:0], leap_c);
		bad_c  = acc_s1.err;
		if (!mode_s1) begin
			if (acc_s1.pos != POS_W'(DATE_LEN)) bad_c = 1'b1;
		end else begin
			if (acc_s1.pos < POS_W'(TIME_LEN) || acc_s1.pos == POS_W'(FRAC_POS)
					|| int'(acc_s1.pos) > MAX_LEN) bad_c = 1'b1;
			if (acc_s1.hour > ACC_W'(MAX_HOUR) || acc_s1.minute > ACC_W'(MAX_MIN_SEC)
					|| acc_s1.second > ACC_W'(MAX_MIN_SEC)) bad_c = 1'b1;
		end
		if (acc_s1.month < ACC_W'(1) || acc_s1.month > ACC_W'(12)) bad_c = 1'b1;
		else if (acc_s1.day < ACC_W'(1) || acc_s1.day > ACC_W'(dim_c)) bad_c = 1'b1;

		// January and February belong to the previous year.
		borrow_c = 1'b0;
		ylo_c    = acc_s1.year_lo;
		if (acc_s1.month <= ACC_W'(2)) begin
			mp_c = 4'(acc_s1.month + ACC_W'(9));
			if (acc_s1.year_lo != '0) begin
				ylo_c = acc_s1.year_lo - ACC_W'(1);
			end else begin
				ylo_c    = ACC_W'(99);
				borrow_c = 1'b1;
			end
		end else begin
			mp_c = 4'(acc_s1.month - ACC_W'(3));
		end
		cent_c = $signed({1'b0, acc_s1.year_hi}) - (borrow_c ? 8'sd1 : 8'sd0);

		days_c = DAY_W'(DAY_W'(cent_c) * DAY_W'(DAYS_PER_CENT))
			+ DAY_W'(cent_c >>> 2)
			+ DAY_W'(DAY_W'(ylo_c) * DAY_W'(DAYS_PER_YEAR))
			+ DAY_W'(ylo_c >> 2)
			+ DAY_W'(month_start(mp_c))
			+ DAY_W'(acc_s1.day)
			- DAY_W'(EPOCH_SHIFT);

		hms_c = HMS_W'(HMS_W'(acc_s1.hour) * HMS_W'(SEC_PER_HOUR))
			+ HMS_W'(HMS_W'(acc_s1.minute) * HMS_W'(SEC_PER_MIN))
			+ HMS_W'(acc_s1.second);

		frac_prod_c = acc_s1.frac * frac_scale(4'(fcnt_s1));
	end

	// Stage 3 logic: seconds since the epoch.
	logic [SEC_W-1:0] secs_c;
	assign secs_c = SEC_W'(SEC_W'(days_s2) * SEC_W'(SEC_PER_DAY)) + SEC_W'(hms_s2);

	// Stage 4 logic: seconds split into halves, each scaled to microseconds.
	logic signed [SEC_W-SEC_LO_W-1:0] shi_c;
	logic [SEC_LO_W-1:0]              slo_c;
	logic [PHI_W-1:0]                 phi_c;
	logic [PLO_W-1:0]                 plo_c;
	assign shi_c = $signed(secs_s3[SEC_W-1:SEC_LO_W]);
	assign slo_c = secs_s3[SEC_LO_W-1:0];
	assign phi_c = PHI_W'(PHI_W'(shi_c) * PHI_W'(US_PER_SEC));
	assign plo_c = PLO_W'(PLO_W'(slo_c) * PLO_W'(US_PER_SEC));

	// Stage 5 logic: final sum and mode select; an invalid value reads as zero.
	logic [VAL_W-1:0] val_c;
	always_comb begin
		if (bad_s4) val_c = '0;
		else if (mode_s4) val_c = {phi_s4, {SEC_LO_W{1'b0}}} + VAL_W'(plo_s4) + VAL_W'(frac_s4);
		else val_c = VAL_W'(days_s4);
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && last_char;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s1  <= acc_d;
			fcnt_s1 <= fcnt_d;
			mode_s1 <= mode_q;

			mode_s2 <= mode_s1;
			bad_s2  <= bad_c;
			days_s2 <= days_c;
			hms_s2  <= hms_c;
			frac_s2 <= frac_prod_c[US_W-1:0];

			mode_s3 <= mode_s2;
			bad_s3  <= bad_s2;
			days_s3 <= days_s2;
			secs_s3 <= secs_c;
			frac_s3 <= frac_s2;

			mode_s4 <= mode_s3;
			bad_s4  <= bad_s3;
			days_s4 <= days_s3;
			phi_s4  <= phi_c;
			plo_s4  <= plo_c;
			frac_s4 <= frac_s3;

			bad_s5  <= bad_s4;
			val_s5  <= val_c;
		end
	end

	assign out_valid   = v_s5;
	assign status      = bad_s5;
	assign epoch_value = $signed(val_s5);

	// An invalid result always carries a zero value.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> epoch_value == '0)
		else $error("invalid result with nonzero value");

	// The last character of a value restarts the scan at position zero.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_char |=> acc_q.pos == '0 && !acc_q.err)
		else $error("scan state not cleared after last character");

	// A format error seen in the scan marks the result invalid.
	a_err_to_bad: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s1 && acc_s1.err |=> v_s2 && bad_s2)
		else $error("format error lost in pipeline");

	// The position counter saturates instead of wrapping.
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_char && acc_q.pos == '1 |=> acc_q.pos == '1)
		else $error("character position wrapped");

endmodule

// ===== tb/date_timestamp_text_parser_core_check.sv =====
// Parse-mode codes and the result checker of the date and timestamp parser testbench.
`timescale 1ns / 100ps

package dtp_tb_pkg;

	// Settings of the one configuration register.
	typedef enum logic {
		MODE_DATE      = 1'b0,
		MODE_TIMESTAMP = 1'b1
	} parse_mode_e;

	// One result word as the parser should deliver it.
	typedef struct packed {
		logic                                status;
		logic signed [dtp_pkg::VAL_W-1:0]    value;
	} parse_result_t;

endpackage

module date_timestamp_text_parser_core_check #(
	parameter int FRACTION_DIGITS = dtp_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_wr_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [7:0]                        char_code,
	input  logic                              last_char,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              status,
	input  logic signed [dtp_pkg::VAL_W-1:0]  epoch_value,
	output int                                results_due,
	output int                                mismatch_total
);
	import dtp_pkg::*;
	import dtp_tb_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam longint US_PER_DAY  = 64'sd86400000000;
	localparam longint US_PER_HOUR = 64'sd3600000000;
	localparam longint US_PER_MIN  = 64'sd60000000;
	localparam longint US_PER_S    = 64'sd1000000;
	localparam int     MONTHS      = 12;

	// Mirror of the register and of the text scan in progress.
	parse_mode_e cur_mode = MODE_TIMESTAMP;
	logic [4:0]  scan_pos;
	logic        scan_bad;
	int unsigned yr, mon, dom, hr, mi, sec, frac_us, frac_n;

	// Results still owed by the parser, oldest first.
	parse_result_t due_results[$];
	parse_result_t want;

	function void clear_scan();
		scan_pos = '0;
		scan_bad = 1'b0;
		yr = 0;
		mon = 0;
		dom = 0;
		hr = 0;
		mi = 0;
		sec = 0;
		frac_us = 0;
		frac_n = 0;
	endfunction

	function bit leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function int unsigned days_in_month(input int unsigned y, input int unsigned m);
		int unsigned n;
		case (m)
			2:           n = leap_year(y) ? 29 : 28;
			4, 6, 9, 11: n = 30;
			default:     n = 31;
		endcase
		return n;
	endfunction

	// Day number relative to 1970-01-01, counting years from March so that
	// the leap day falls at the end of each counted year.
	function longint civil_to_epoch_day(input int unsigned y, input int unsigned m,
			input int unsigned d);
		longint ya, era, yoe, mp, doy, doe;
		ya = longint'(y) - ((m <= 2) ? 1 : 0);
		era = ((ya >= 0) ? ya : ya - 399) / 400;
		yoe = ya - era * 400;
		mp = (m > 2) ? longint'(m) - 3 : longint'(m) + 9;
		doy = (153 * mp + 2) / 5 + longint'(d) - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	// Fold one text byte into the field that its position selects.
	function void scan_byte(input logic [7:0] c);
		logic        is_dig;
		int unsigned dv;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		dv = is_dig ? int'(c - CH_ZERO) : 0;
		if (scan_pos <= 3) begin
			if (is_dig) yr = yr * 10 + dv; else scan_bad = 1'b1;
		end else if (scan_pos == 4 || scan_pos == 7) begin
			if (c != CH_DASH) scan_bad = 1'b1;
		end else if (scan_pos == 5 || scan_pos == 6) begin
			if (is_dig) mon = mon * 10 + dv; else scan_bad = 1'b1;
		end else if (scan_pos == 8 || scan_pos == 9) begin
			if (is_dig) dom = dom * 10 + dv; else scan_bad = 1'b1;
		end else if (scan_pos == DATE_LEN) begin
			if (c != CH_SPACE && c != CH_T) scan_bad = 1'b1;
		end else if (scan_pos == 11 || scan_pos == 12) begin
			if (is_dig) hr = hr * 10 + dv; else scan_bad = 1'b1;
		end else if (scan_pos == 13 || scan_pos == 16) begin
			if (c != CH_COLON) scan_bad = 1'b1;
		end else if (scan_pos == 14 || scan_pos == 15) begin
			if (is_dig) mi = mi * 10 + dv; else scan_bad = 1'b1;
		end else if (scan_pos == 17 || scan_pos == 18) begin
			if (is_dig) sec = sec * 10 + dv; else scan_bad = 1'b1;
		end else if (scan_pos == TIME_LEN) begin
			if (c != CH_DOT) scan_bad = 1'b1;
		end else if (scan_pos < FRAC_POS + FRACTION_DIGITS) begin
			// Digits past the sixth are checked but do not change the value.
			if (!is_dig) begin
				scan_bad = 1'b1;
			end else begin
				if (frac_n < US_DIGITS) frac_us = frac_us * 10 + dv;
				frac_n++;
			end
		end else begin
			scan_bad = 1'b1;
		end
		if (scan_pos != 5'd31) scan_pos++;
	endfunction

	// Status and epoch value of the text scanned so far, under the current mode.
	function parse_result_t epoch_of_text();
		parse_result_t res;
		int unsigned   len;
		logic          bad;
		longint        days, frac, us;
		len = scan_pos;
		bad = scan_bad;
		if (cur_mode == MODE_DATE) begin
			if (len != DATE_LEN) bad = 1'b1;
		end else begin
			if (len < TIME_LEN || len == FRAC_POS || len > FRAC_POS + FRACTION_DIGITS)
				bad = 1'b1;
			if (hr > MAX_HOUR || mi > MAX_MIN_SEC || sec > MAX_MIN_SEC) bad = 1'b1;
		end
		if (mon < 1 || mon > MONTHS) bad = 1'b1;
		else if (dom < 1 || dom > days_in_month(yr, mon)) bad = 1'b1;

		res.status = bad;
		res.value = '0;
		if (!bad) begin
			days = civil_to_epoch_day(yr, mon, dom);
			if (cur_mode == MODE_DATE) begin
				res.value = days[VAL_W-1:0];
			end else begin
				// Short fractions are scaled up to whole microseconds.
				frac = longint'(frac_us);
				for (int k = frac_n; k < US_DIGITS; k++) frac = frac * 10;
				us = days * US_PER_DAY + longint'(hr) * US_PER_HOUR
					+ longint'(mi) * US_PER_MIN + longint'(sec) * US_PER_S + frac;
				res.value = us[VAL_W-1:0];
			end
		end
		clear_scan();
		return res;
	endfunction

	// Watch both channels and the register port on every edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = MODE_TIMESTAMP;
			clear_scan();
			due_results.delete();
			results_due = 0;
			mismatch_total = 0;
		end else begin
			// Register write.
			if (cfg_wr_en) cur_mode = parse_mode_e'(cfg_wr_data);

			// Result word: compare with the oldest owed result.
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= MAX_REPORTS)
						$display("%0t: unexpected result word: status %0d value %0d",
							$time, status, epoch_value);
				end else begin
					want = due_results.pop_front();
					if (status !== want.status || epoch_value !== want.value) begin
						mismatch_total++;
						if (mismatch_total <= MAX_REPORTS)
							$display("%0t: expected status %0d value %0d, got %0d %0d",
								$time, want.status, want.value, status, epoch_value);
					end
				end
			end

			// Character word: scan it, and on the final byte queue the result.
			if (in_valid && in_ready) begin
				scan_byte(char_code);
				if (last_char) due_results.insert(due_results.size(), epoch_of_text());
			end
			results_due = due_results.size();
		end
	end

endmodule

// ===== tb/date_timestamp_text_parser_core_tb.sv =====
// Stimulus, clock, reset and verdict of the date and timestamp parser testbench.
`timescale 1ns / 100ps

module date_timestamp_text_parser_core_tb;
	import dtp_pkg::*;
	import dtp_tb_pkg::*;

	localparam int FRACTION_DIGITS = FRACTION_DIGITS_DEF;
	localparam int RESET_CYCLES    = 9;
	localparam int SETTLE_CYCLES   = 12;
	localparam int PHASES          = 8;
	localparam int PHASE_CHARS     = 150;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_e;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_wr_en = 1'b0;
	logic                        cfg_wr_data = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [7:0]                  char_code = 8'h00;
	logic                        last_char = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        status;
	logic signed [VAL_W-1:0]     epoch_value;
	int                          results_due;
	int                          mismatch_total;

	// Text of the value being sent, and sender bookkeeping.
	logic [7:0]  text_buf[$];
	parse_mode_e mode_now = MODE_TIMESTAMP;
	int unsigned burst_left = 0;
	int unsigned sent_count = 0;

	date_timestamp_text_parser_core #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.epoch_value(epoch_value)
	);

	date_timestamp_text_parser_core_check #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) epoch_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.epoch_value(epoch_value),
		.results_due(results_due),
		.mismatch_total(mismatch_total)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop in case the parser hangs or owes results forever.
	initial begin
		#10_000_000;
		$display("date_timestamp_text_parser_core_tb failed");
		$finish;
	end

	// Receiver: a stall style picked at random, and picked anew after each random run.
	rx_style_e   rx_style = RX_ALWAYS;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_e'($urandom_range(0, 3));
			rx_left = $urandom_range(32, 256);
		end else begin
			rx_left--;
		end
		rx_tick++;
		case (rx_style)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= ((rx_tick % 7) < 2);
		endcase
	end

	// Send one character word; bursts of random length with random gaps between.
	task send_char(input logic [7:0] c, input logic fin);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	// Stop sending, wait until every owed result has come out, and let the bench settle.
	task settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_mode(input parse_mode_e m);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_now = m;
	endtask

	// Send the buffered text; at index cut the mode is switched in mid-value.
	task send_text(input int cut, input parse_mode_e cut_mode);
		for (int i = 0; i < text_buf.size(); i++) begin
			if (i == cut) begin
				settle();
				write_mode(cut_mode);
			end
			send_char(text_buf[i], i == text_buf.size() - 1);
		end
		text_buf.delete();
	endtask

	// Add one byte at the end of the text buffer.
	task append_byte(input logic [7:0] b);
		text_buf.insert(text_buf.size(), b);
	endtask

	task push_str(input string s);
		for (int i = 0; i < s.len(); i++) append_byte(s[i]);
	endtask

	task push_num(input int unsigned v, input int unsigned n);
		int unsigned scale;
		scale = 1;
		repeat (n - 1) scale *= 10;
		repeat (n) begin
			append_byte(8'(CH_ZERO + (v / scale) % 10));
			scale /= 10;
		end
	endtask

	task send_str(input string s);
		push_str(s);
		send_text(-1, mode_now);
	endtask

	// Build a date or timestamp with random fields, mostly well formed.
	task build_value(input logic as_stamp);
		int unsigned y, m, d, h, mn, s, nfrac, pick;
		pick = $urandom_range(0, 9);
		y = (pick == 0) ? 0 : (pick == 1) ? 9999 : (pick == 2) ? 100 * $urandom_range(0, 99)
			: (pick == 3) ? 4 * $urandom_range(0, 2499) : $urandom_range(0, 9999);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			m = 2;
			d = 29;
		end else begin
			m = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
			d = (pick == 1) ? $urandom_range(0, 99) : (pick <= 3) ? $urandom_range(28, 31)
				: $urandom_range(1, 28);
		end
		push_num(y, 4);
		append_byte(CH_DASH);
		push_num(m, 2);
		append_byte(CH_DASH);
		push_num(d, 2);

		if (as_stamp) begin
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
			mn = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
			s = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
			append_byte($urandom_range(0, 1) ? CH_T : CH_SPACE);
			push_num(h, 2);
			append_byte(CH_COLON);
			push_num(mn, 2);
			append_byte(CH_COLON);
			push_num(s, 2);
			// Fraction: none, a bare dot, one digit too many, or a legal count.
			pick = $urandom_range(0, 9);
			if (pick >= 3) begin
				nfrac = (pick == 3) ? 0 : (pick == 4) ? FRACTION_DIGITS + 1
					: $urandom_range(1, FRACTION_DIGITS);
				append_byte(CH_DOT);
				repeat (nfrac) append_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
			end
		end

		// Now and then break the text: a stray byte, a cut tail, or extra bytes.
		pick = $urandom_range(0, 9);
		if (pick == 0)
			text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
		else if (pick == 1)
			repeat ($urandom_range(1, text_buf.size() - 1))
				text_buf.delete(text_buf.size() - 1);
		else if (pick == 2)
			repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
	endtask

	// Random bytes, long enough at times to saturate the position counter.
	task build_noise();
		int unsigned n;
		n = $urandom_range(1, 40);
		repeat (n)
			append_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(CH_ZERO, CH_NINE)));
	endtask

	initial begin
		int unsigned pick, phase_start;
		int          cut;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// Timestamp mode: epoch, both ends of the range, leap day, bad fields.
		write_mode(MODE_TIMESTAMP);
		send_str("1970-01-01T00:00:00");
		send_str("9999-12-31 23:59:59.999999");
		send_str("0000-01-01T00:00:00");
		send_str("2000-02-29T12:34:56.5");
		send_str("1900-02-29 00:00:00");
		send_str("2024-06-15T24:00:00");
		send_str("2024-06-15T23:60:00");
		send_str("2024-06-15T23:59:60");
		send_str("2024-06-15T10:20:30.");
		send_str("2024-06-15T10:20:30.1234567");
		send_str("2024-06-15X10:20:30");
		send_str("2O24-06-15T10:20:30.123");
		settle();

		// Date mode: both ends of the range, month and day limits, wrong lengths.
		write_mode(MODE_DATE);
		send_str("1970-01-01");
		send_str("0000-01-01");
		send_str("9999-12-31");
		send_str("2023-02-29");
		send_str("2024-13-01");
		send_str("2024-04-31");
		send_str("2024-01-00");
		send_str("2024-01-011");
		send_str("7");

		// Mode switched in mid-value: the mode at the final byte decides.
		push_str("1999-12-31T23:59:59.123");
		send_text(8, MODE_TIMESTAMP);
		push_str("2001-09-09");
		send_text(3, MODE_DATE);

		// Random phases, each begun under one mode setting that a mid-value switch may change.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_mode((ph == 0) ? MODE_TIMESTAMP : (ph == 1) ? MODE_DATE
				: parse_mode_e'($urandom_range(0, 1)));
			phase_start = sent_count;
			while (sent_count - phase_start < PHASE_CHARS) begin
				pick = $urandom_range(0, 19);
				if (pick < 2) build_noise();
				else if (pick == 2) build_value(mode_now == MODE_DATE);
				else build_value(mode_now == MODE_TIMESTAMP);
				cut = (pick == 3) ? int'($urandom_range(0, text_buf.size() - 1)) : -1;
				send_text(cut, parse_mode_e'(~mode_now));
			end
		end

		settle();
		if (mismatch_total == 0)
			$display("date_timestamp_text_parser_core_tb passed");
		else
			$display("date_timestamp_text_parser_core_tb failed");
		$finish;
	end

endmodule
